// ===== hdl/bopd_pkg.sv =====
package bopd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned COUNT_W  = 25;
  localparam int unsigned GATHER_W = 24;

  // Marker byte that announces a wider delta, and the 16-bit value that
  // announces a 32-bit delta.
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h80;
  localparam logic [15:0]       ESC_WORD = 16'h8000;

  // Largest image the decoder handles; larger counts are clamped to it.
  localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'd16777216;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = 1;

  typedef logic [PIXEL_W-1:0] delta_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_LO16 = 7'b0000010,
    PH_HI16 = 7'b0000100,
    PH_B0   = 7'b0001000,
    PH_B1   = 7'b0010000,
    PH_B2   = 7'b0100000,
    PH_B3   = 7'b1000000
  } phase_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_status_t;

endpackage

// ===== hdl/bopd_byte_if.sv =====
interface bopd_byte_if;
  import bopd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/bopd_pixel_if.sv =====
interface bopd_pixel_if;
  import bopd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PIXEL_W-1:0] pixel_value;
  logic                      last_pixel;

  modport source (output valid, output pixel_value, output last_pixel, input ready);
  modport sink (input valid, input pixel_value, input last_pixel, output ready);
endinterface

// ===== hdl/bopd_front.sv =====
module bopd_front (
  input  logic                clk,
  input  logic                rst_n,
  bopd_byte_if.sink           in_bus,
  input  bopd_pkg::fifo_status_t fifo_stat,
  output logic                push,
  output bopd_pkg::delta_t    push_delta
);
  import bopd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [GATHER_W-1:0] gather_r, gather_nxt;
  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic [15:0]         word16;

  assign in_bus.ready = !fifo_stat.full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.data_byte;
  assign word16       = {b, gather_r[7:0]};

  always_comb begin
    phase_nxt  = phase_r;
    gather_nxt = gather_r;
    push       = 1'b0;
    push_delta = '0;
    if (accept) begin
      unique case (phase_r)
        PH_LO16: begin
          gather_nxt = {{(GATHER_W-BYTE_W){1'b0}}, b};
          phase_nxt  = PH_HI16;
        end
        PH_HI16: begin
          if (word16 == ESC_WORD) begin
            phase_nxt = PH_B0;
          end else begin
            push       = 1'b1;
            push_delta = {{(PIXEL_W-16){word16[15]}}, word16};
            phase_nxt  = PH_IDLE;
          end
        end
        PH_B0: begin
          gather_nxt = {{(GATHER_W-BYTE_W){1'b0}}, b};
          phase_nxt  = PH_B1;
        end
        PH_B1: begin
          gather_nxt[15:8] = b;
          phase_nxt        = PH_B2;
        end
        PH_B2: begin
          gather_nxt[23:16] = b;
          phase_nxt         = PH_B3;
        end
        PH_B3: begin
          push       = 1'b1;
          push_delta = {b, gather_r};
          phase_nxt  = PH_IDLE;
        end
        default: begin
          if (b == ESC_BYTE) begin
            phase_nxt = PH_LO16;
          end else begin
            push       = 1'b1;
            push_delta = {{(PIXEL_W-BYTE_W){b[7]}}, b};
            phase_nxt  = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gather_r <= gather_nxt;
  end

endmodule

// ===== hdl/bopd_fifo.sv =====
module bopd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  bopd_pkg::delta_t       push_delta,
  input  logic                   pop,
  output bopd_pkg::delta_t       pop_delta,
  output bopd_pkg::fifo_status_t status
);
  import bopd_pkg::*;

  delta_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign status.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status.valid = (count_r != '0);
  assign pop_delta    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_delta;
    end
  end

endmodule

// ===== hdl/bopd_back.sv =====
module bopd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bopd_pkg::count_t       limit,
  input  bopd_pkg::fifo_status_t fifo_stat,
  input  bopd_pkg::delta_t       delta,
  output logic                   pop,
  bopd_pixel_if.source           out_bus
);
  import bopd_pkg::*;

  logic [PIXEL_W-1:0] sum_r, sum_nxt, new_sum;
  count_t             done_r, done_nxt, done_inc;
  logic               out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0] pixel_r;
  logic               last_r;
  logic               is_last;

  assign pop      = fifo_stat.valid && (!out_valid_r || out_bus.ready);
  assign new_sum  = sum_r + delta;
  assign done_inc = done_r + 1'b1;
  assign is_last  = (done_inc >= limit);

  always_comb begin
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      // The final pixel of an image restarts the sum and the count.
      sum_nxt  = is_last ? '0 : new_sum;
      done_nxt = is_last ? '0 : done_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_r <= new_sum;
      last_r  <= is_last;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.pixel_value = $signed(pixel_r);
  assign out_bus.last_pixel  = last_r;

endmodule

// ===== hdl/byte_offset_pixel_decoder.sv =====
// Byte-offset pixel decoder.
// The input channel in_bus carries one compressed byte per word. A byte other
// than 0x80 is an 8-bit delta; 0x80 opens a 16-bit little-endian delta, and a
// 16-bit value of 0x8000 opens a 32-bit one. The output channel out_bus
// carries one pixel word per completed delta: the running sum of deltas
// and a flag on the last pixel of an image.
// cfg_we/cfg_wdata set the pixel count per image (0 acts as 1, values above
// the maximum image size are clamped); write it only while the decoder is idle.
// Throughput is one byte per cycle; the input stalls only when the two-entry
// delta queue is full. A byte that completes a delta is written into the delta
// queue; when the output register is free, the accumulated sum is loaded into
// it and appears as a pixel on out_bus.
// When the receiver stalls, the output register holds its word, the queue
// fills, and in_bus.ready drops until out_bus.ready returns.
// Reset (synchronous, active low) clears the decode phase, the sum, the pixel
// count of the current image and the queue, and sets the pixel count to 1.
module byte_offset_pixel_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  bopd_byte_if.sink                   in_bus,
  bopd_pixel_if.source                out_bus,
  input  logic                        cfg_we,
  input  logic [bopd_pkg::COUNT_W-1:0] cfg_wdata
);
  import bopd_pkg::*;

  count_t       limit_r;
  fifo_status_t fifo_stat;
  logic         push, pop;
  delta_t       push_delta, pop_delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= count_t'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        limit_r <= count_t'(1);
      end else if (cfg_wdata > MAX_PIXELS) begin
        limit_r <= MAX_PIXELS;
      end else begin
        limit_r <= cfg_wdata;
      end
    end
  end

  bopd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_delta (push_delta)
  );

  bopd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_delta (push_delta),
    .pop        (pop),
    .pop_delta  (pop_delta),
    .status     (fifo_stat)
  );

  bopd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .fifo_stat (fifo_stat),
    .delta     (pop_delta),
    .pop       (pop),
    .out_bus   (out_bus)
  );

endmodule

// ===== sim/bopd_pixel_checker.sv =====
`timescale 1ns / 100ps

module bopd_pixel_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bopd_pkg::BYTE_W-1:0]  in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bopd_pkg::PIXEL_W-1:0] out_pixel,
  input  logic                         out_last,
  input  logic                         cfg_we,
  input  bopd_pkg::count_t             cfg_wdata,
  output int                           errors,
  output int                           pending,
  output int                           bytes_seen,
  output int                           pixels_seen,
  output int                           images_seen
);
  import bopd_pkg::*;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               last;
  } pixel_word_t;

  pixel_word_t pixel_q[$];

  count_t image_size;
  count_t pixels_done;
  phase_t phase;
  delta_t partial;
  delta_t pixel_sum;

  function automatic count_t image_limit(input count_t n);
    if (n == '0) begin
      return count_t'(1);
    end
    if (n > MAX_PIXELS) begin
      return MAX_PIXELS;
    end
    return n;
  endfunction

  task automatic finish_pixel(input delta_t delta);
    pixel_word_t w;
    pixel_sum   = pixel_sum + delta;
    pixels_done = pixels_done + 1'b1;
    w.value     = pixel_sum;
    w.last      = (pixels_done >= image_limit(image_size));
    pixel_q.push_back(w);
    phase   = PH_IDLE;
    partial = '0;
    if (w.last) begin
      pixel_sum   = '0;
      pixels_done = '0;
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [15:0] word16;
    case (phase)
      PH_LO16: begin
        partial = {24'd0, b};
        phase   = PH_HI16;
      end
      PH_HI16: begin
        word16 = {b, partial[7:0]};
        // The escape value opens a four-byte delta instead of ending one.
        if (word16 == ESC_WORD) begin
          partial = '0;
          phase   = PH_B0;
        end else begin
          finish_pixel({{16{word16[15]}}, word16});
        end
      end
      PH_B0: begin
        partial = {24'd0, b};
        phase   = PH_B1;
      end
      PH_B1: begin
        partial[15:8] = b;
        phase         = PH_B2;
      end
      PH_B2: begin
        partial[23:16] = b;
        phase          = PH_B3;
      end
      PH_B3: begin
        finish_pixel({b, partial[23:0]});
      end
      default: begin
        if (b == ESC_BYTE) begin
          partial = '0;
          phase   = PH_LO16;
        end else begin
          finish_pixel({{24{b[7]}}, b});
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    pixel_word_t exp_w;
    if (!rst_n) begin
      pixel_q.delete();
      image_size  = count_t'(1);
      pixels_done = '0;
      phase       = PH_IDLE;
      partial     = '0;
      pixel_sum   = '0;
      errors      = 0;
      bytes_seen  = 0;
      pixels_seen = 0;
      images_seen = 0;
    end else begin
      // A word leaving now can never be caused by a byte entering at the same edge.
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel word, got value %h last %b",
                   $time, out_pixel, out_last);
        end else begin
          exp_w = pixel_q.pop_front();
          if (out_pixel !== exp_w.value) begin
            errors++;
            $display("%0t: pixel_value mismatch, expected %h got %h",
                     $time, exp_w.value, out_pixel);
          end
          if (out_last !== exp_w.last) begin
            errors++;
            $display("%0t: last_pixel mismatch, expected %b got %b",
                     $time, exp_w.last, out_last);
          end
          if (exp_w.last) begin
            images_seen++;
          end
        end
      end
      if (cfg_we) begin
        image_size = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        decode_byte(in_data);
      end
    end
    pending = pixel_q.size();
  end

endmodule

// ===== sim/tb_byte_offset_pixel_decoder.sv =====
`timescale 1ns / 100ps

module tb_byte_offset_pixel_decoder;
  import bopd_pkg::*;

  typedef enum int {
    DELTA8,
    DELTA16,
    DELTA32
  } delta_kind_t;

  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 10;
  localparam int PHASE_BYTES   = 100;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  bopd_byte_if  in_bus();
  bopd_pixel_if out_bus();

  int errors;
  int pending;
  int bytes_seen;
  int pixels_seen;
  int images_seen;

  bit send_idle;
  bit recv_idle;
  int hold_requests;
  int bytes_sent;
  int settings_used;

  byte_offset_pixel_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  bopd_pixel_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_data    (in_bus.data_byte),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_pixel  (out_bus.pixel_value),
    .out_last   (out_bus.last_pixel),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .bytes_seen (bytes_seen),
    .pixels_seen(pixels_seen),
    .images_seen(images_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_byte_offset_pixel_decoder: errors");
    $finish;
  end

  // Receiver: a random hold-off before each word while recv_idle is set, plus one long hold-off per request.
  initial begin : receiver
    int gap;
    int holds_done;
    holds_done    = 0;
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_idle ? $urandom_range(6) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = send_idle ? $urandom_range(6) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_delta(input delta_kind_t kind, input delta_t d);
    case (kind)
      DELTA8: begin
        send_byte(d[7:0]);
      end
      DELTA16: begin
        send_byte(ESC_BYTE);
        send_byte(d[7:0]);
        send_byte(d[15:8]);
      end
      default: begin
        send_byte(ESC_BYTE);
        send_byte(ESC_WORD[7:0]);
        send_byte(ESC_WORD[15:8]);
        send_byte(d[7:0]);
        send_byte(d[15:8]);
        send_byte(d[23:16]);
        send_byte(d[31:24]);
      end
    endcase
  endtask

  // Stop offering bytes and wait until every pixel word has been taken.
  task automatic drain_pixels();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pixel_count(input count_t n);
    drain_pixels();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_delta();
    int     pick;
    delta_t d;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(99);
    d    = $urandom;
    case ($urandom_range(19))
      0: d = 32'h7FFF_FFFF;
      1: d = 32'h8000_0000;
      2: d = 32'hFFFF_FFFF;
      default: ;
    endcase
    if (pick < 45) begin
      do b = BYTE_W'($urandom_range(255)); while (b == ESC_BYTE);
      send_delta(DELTA8, {24'd0, b});
    end else if (pick < 75) begin
      send_delta(DELTA16, d);
    end else if (pick < 92) begin
      send_delta(DELTA32, d);
    end else begin
      // Loose bytes, which may also open or break up a wide delta.
      send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    count_t phase_counts[PHASES];
    int     target;
    bit     mid_drained;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    send_idle        = 1'b1;
    recv_idle        = 1'b1;
    hold_requests    = 0;
    bytes_sent       = 0;
    settings_used    = 0;
    mid_drained      = 1'b0;
    phase_counts = '{count_t'(1), count_t'(0), count_t'(3), count_t'(16),
                     count_t'($urandom_range(40, 1)), MAX_PIXELS, 25'h1FF_FFFF,
                     count_t'(2), count_t'(7), count_t'($urandom)};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the count left at its reset value every pixel closes an image.
    send_delta(DELTA8, 32'h05);
    set_pixel_count(count_t'(0));
    send_delta(DELTA8, 32'hFF);

    set_pixel_count(count_t'(12));
    send_delta(DELTA8, 32'h00);
    send_delta(DELTA8, 32'h7F);
    send_delta(DELTA8, 32'h81);
    send_delta(DELTA8, 32'hFF);
    send_delta(DELTA16, 32'h7FFF);
    send_delta(DELTA16, 32'h8001);
    send_delta(DELTA16, 32'hFFFF);
    send_delta(DELTA16, 32'h0080);
    send_delta(DELTA32, 32'h7FFF_FFFF);
    send_delta(DELTA32, 32'h8000_0000);
    send_delta(DELTA32, 32'hFFFF_FFFF);
    send_delta(DELTA32, 32'h0000_0000);

    // Shrinking the count below the pixels already done flags the next pixel.
    set_pixel_count(count_t'(20));
    repeat (5) send_delta(DELTA8, 32'h11);
    set_pixel_count(count_t'(3));
    send_delta(DELTA8, 32'h22);

    for (int p = 0; p < PHASES; p++) begin
      set_pixel_count(phase_counts[p]);
      send_idle = (p % 3 != 2);
      recv_idle = (p % 4 != 1);
      if (p == 3) begin
        send_idle     = 1'b0;
        hold_requests = hold_requests + 1;
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if (p == 6 && !mid_drained && bytes_sent >= target - PHASE_BYTES / 2) begin
          mid_drained = 1'b1;
          drain_pixels();
        end
        random_delta();
      end
    end

    drain_pixels();
    repeat (10) @(posedge clk);
    $display("Decoded %0d bytes into %0d pixel words and %0d complete images",
             bytes_seen, pixels_seen, images_seen);
    $display("over %0d pixel-count settings, with and without stalls on both sides.",
             settings_used);
    if (errors == 0 && pending == 0) begin
      $display("tb_byte_offset_pixel_decoder: clean");
    end else begin
      $display("tb_byte_offset_pixel_decoder: errors");
    end
    $finish;
  end

endmodule
